FILE: rtl/bra_pkg.sv
// Package for the barometric relative altitude block: constants, state
// codes, rounding helper and the log2 / exp2 interpolation tables.
// No dependencies; used by every module under rtl.
package bra_pkg;

    // fixed point layout
    localparam int FRAC_BITS     = 16;
    localparam int LQ            = 28;
    localparam int TBL_BITS      = 8;
    localparam int TABLE_ENTRIES = 1 << TBL_BITS;
    localparam int H_SHIFT       = LQ + 16 - FRAC_BITS;

    // field widths
    localparam int P_W    = 17;
    localparam int W_W    = 17;
    localparam int H_W    = 31;
    localparam int S_W    = 32;
    localparam int QUO_W  = LQ + 2;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // divider
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // constants
    localparam logic [P_W-1:0]    P_MIN     = 17'd30000;
    localparam logic [P_W-1:0]    P_MAX     = 17'd110000;
    localparam logic [W_W-1:0]    W_ONE     = 17'd65536;
    localparam logic [W_W-1:0]    W_RESET   = 17'd1311;
    localparam logic signed [MUL_W-1:0] EXPO_Q28  = 33'sd51073335;
    localparam logic signed [MUL_W-1:0] SCALE_Q16 = 33'sd2905261343;
    localparam logic signed [PROD_W-1:0] H_MAX = 66'sd1073741823;
    localparam logic signed [PROD_W-1:0] H_MIN = -66'sd1073741824;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    // input kind and register map
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;
    localparam logic REG_WEIGHT   = 1'b0;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_NORM,
        S_LMUL,
        S_LSUM,
        S_YMUL,
        S_YRND,
        S_EMUL,
        S_ESUM,
        S_HMUL,
        S_HRND,
        S_AMUL1,
        S_AMUL2,
        S_ASUM,
        S_ARND,
        S_OUT
    } state_t;

    typedef logic [31:0] rom_t [0:TABLE_ENTRIES];

    // log2(1 + i/N) in Q28 by repeated squaring
    function automatic rom_t build_log_rom();
        rom_t rom;
        logic [63:0] v;
        logic [63:0] r;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            v = ((64'(TABLE_ENTRIES) + 64'(i)) << 30) / TABLE_ENTRIES;
            r = '0;
            if (v >= (64'd2 << 30)) begin
                rom[i] = 32'd1 << LQ;
            end else begin
                for (int k = 0; k < LQ + 1; k++) begin
                    v = (v * v) >> 30;
                    r = r << 1;
                    if (v >= (64'd2 << 30)) begin
                        v = v >> 1;
                        r = r | 64'd1;
                    end
                end
                rom[i] = 32'((r + 64'd1) >> 1);
            end
        end
        return rom;
    endfunction

    // 2^(i/N) in Q28 by series of exp
    function automatic rom_t build_exp_rom();
        rom_t rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            x = (64'(i) * LN2_Q30 + 64'(TABLE_ENTRIES / 2)) / TABLE_ENTRIES;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k < 25; k++) begin
                term = ((term * x) >> 30) / 64'(k);
                sum = sum + term;
            end
            rom[i] = 32'((sum + 64'd2) >> 2);
        end
        return rom;
    endfunction

    localparam rom_t LOG_ROM = build_log_rom();
    localparam rom_t EXP_ROM = build_exp_rom();

    // round half away from zero, then shift right
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int sh
    );
        logic [PROD_W-1:0] u;
        logic [PROD_W-1:0] half;
        half = {{(PROD_W-1){1'b0}}, 1'b1} << (sh - 1);
        u = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        u = (u + half) >> sh;
        return v[PROD_W-1] ? -$signed(u) : $signed(u);
    endfunction

endpackage

FILE: rtl/bra_div.sv
// Restoring divider for the pressure ratio (p << LQ) / base, one quotient
// bit a cycle. Depends on bra_pkg.
module bra_div import bra_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [P_W-1:0]   dividend,
    input  logic [P_W-1:0]   divisor,
    output logic             busy,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [P_W-1:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [P_W:0]         cand;
    logic                 ge;

    // one trial subtraction
    always_comb begin
        cand     = {rem_reg, q_reg[QUO_W-1]};
        ge       = cand >= {1'b0, divisor};
        rem_next = ge ? P_W'(cand - {1'b0, divisor}) : cand[P_W-1:0];
        q_next   = {q_reg[QUO_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {2'b00, dividend[P_W-1:2]};
            q_reg   <= {dividend[1:0], {LQ{1'b0}}};
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/bra_mul.sv
// Shared signed multiplier with registered product, used for every
// product of the height computation. Depends on bra_pkg.
module bra_mul import bra_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/barometric_relative_altitude.sv
// Top level of the barometric relative altitude block: sequencer, state
// registers, register port and result register.
// Depends on bra_pkg, bra_div and bra_mul.
//
//  channel  | ports             | contents (lsb first)
//  ---------+-------------------+-------------------------------------------
//  input    | s_tvalid/s_tready | s_tdata: pressure_pa; s_tuser: mode
//  result   | m_tvalid/m_tready | m_tdata: relative_height, base_valid
//  register | psel/penable/...  | 0x0: smoothing_weight
//
// A sample item with a base set runs through the accepting step, the divide
// step (30 quotient bits), normalising the ratio, the steps around the shared
// multiplier (S_LMUL to S_ARND) and the output step. Capture items and samples
// without a base go from the accepting step straight to the output step.
// Reset is synchronous; no clearing pass is needed.
// The next request is taken while a result waits in the output register;
// the sequencer holds in its last step while that register is full.
module barometric_relative_altitude import bra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] pressure_pa
    input  logic [0:0]  s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] relative_height, [31] base_valid
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    logic [W_W-1:0]          weight_reg;
    logic [P_W-1:0]          last_reg, base_reg, p_reg;
    logic                    base_set_reg;
    logic signed [S_W-1:0]   smooth_reg;
    logic [QUO_W-1:0]        norm_reg;
    logic [4:0]              e_reg;
    logic signed [31:0]      l_reg, y_reg, d_reg;
    logic signed [S_W-1:0]   h_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;

    logic [P_W-1:0]          p_clamp;
    logic                    s_fire, load_out, base_ok, div_start;
    logic                    div_busy, div_done;
    logic [QUO_W-1:0]        div_q;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic [W_W-1:0]          w_eff;

    logic [TBL_BITS-1:0]     lidx, eidx;
    logic [19:0]             lfrac;
    logic [LQ-1:0]           efrac;
    logic signed [6:0]       em;
    logic signed [31:0]      l_next;
    logic [31:0]             pw_raw, pw_sh;
    logic signed [3:0]       n_raw, n_cl;
    logic signed [PROD_W-1:0] y_round, h_round, s_round;

    // clamp and handshake
    always_comb begin
        if (s_tdata[P_W-1:0] < P_MIN) begin
            p_clamp = P_MIN;
        end else if (s_tdata[P_W-1:0] > P_MAX) begin
            p_clamp = P_MAX;
        end else begin
            p_clamp = s_tdata[P_W-1:0];
        end
        s_fire   = s_tvalid && s_tready;
        base_ok  = base_set_reg && (base_reg != '0);
        load_out = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
        w_eff    = (weight_reg > W_ONE) ? W_ONE : weight_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == MODE_SAMPLE && base_ok) begin
                        state_next = S_DIV;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:   if (div_done) state_next = S_NORM;
            S_NORM:  if (norm_reg[QUO_W-1]) state_next = S_LMUL;
            S_LMUL:  state_next = S_LSUM;
            S_LSUM:  state_next = S_YMUL;
            S_YMUL:  state_next = S_YRND;
            S_YRND:  state_next = S_EMUL;
            S_EMUL:  state_next = S_ESUM;
            S_ESUM:  state_next = S_HMUL;
            S_HMUL:  state_next = S_HRND;
            S_HRND:  state_next = S_AMUL1;
            S_AMUL1: state_next = S_AMUL2;
            S_AMUL2: state_next = S_ASUM;
            S_ASUM:  state_next = S_ARND;
            S_ARND:  state_next = S_OUT;
            S_OUT:   if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // table indices
    always_comb begin
        lidx  = norm_reg[QUO_W-2 -: TBL_BITS];
        lfrac = {norm_reg[QUO_W-2-TBL_BITS -: (20-TBL_BITS)], {TBL_BITS{1'b0}}};
        eidx  = y_reg[LQ-1 -: TBL_BITS];
        efrac = {y_reg[LQ-1-TBL_BITS:0], {TBL_BITS{1'b0}}};
    end

    // sequencer outputs: multiplier operands and divider start
    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        div_start = (state_reg == S_IDLE) && s_tvalid
                    && (s_tuser[0] == MODE_SAMPLE) && base_ok;
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_LMUL: begin
                op_a = $signed({1'b0, LOG_ROM[{1'b0, lidx} + 1'b1]
                                      - LOG_ROM[{1'b0, lidx}]});
                op_b = $signed(MUL_W'(lfrac));
            end
            S_YMUL: begin
                op_a = MUL_W'(l_reg);
                op_b = EXPO_Q28;
            end
            S_EMUL: begin
                op_a = $signed({1'b0, EXP_ROM[{1'b0, eidx} + 1'b1]
                                      - EXP_ROM[{1'b0, eidx}]});
                op_b = $signed(MUL_W'(efrac));
            end
            S_HMUL: begin
                op_a = MUL_W'(d_reg);
                op_b = SCALE_Q16;
            end
            S_AMUL1: begin
                op_a = $signed(MUL_W'(W_ONE - w_eff));
                op_b = MUL_W'(smooth_reg);
            end
            S_AMUL2: begin
                op_a = $signed(MUL_W'(w_eff));
                op_b = MUL_W'(h_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // step arithmetic around the multiplier
    always_comb begin
        em      = $signed({2'b00, e_reg}) - 7'sd28;
        l_next  = (32'(em) <<< LQ) + $signed(LOG_ROM[{1'b0, lidx}])
                  + $signed(32'((prod + 66'sd524288) >>> 20));
        y_round = round_shift(prod, LQ);
        n_raw   = y_reg[31:LQ];
        if (n_raw > 4'sd1) begin
            n_cl = 4'sd1;
        end else if (n_raw < -4'sd2) begin
            n_cl = -4'sd2;
        end else begin
            n_cl = n_raw;
        end
        pw_raw  = EXP_ROM[{1'b0, eidx}] + 32'((prod + 66'sd134217728) >>> LQ);
        pw_sh   = n_cl[3] ? (pw_raw >> 2'(-n_cl)) : (pw_raw << n_cl[1:0]);
        h_round = round_shift(prod, H_SHIFT);
        s_round = round_shift(acc_reg, 16);
    end

    // control state and item state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            weight_reg   <= W_RESET;
            last_reg     <= '0;
            base_reg     <= '0;
            base_set_reg <= 1'b0;
            smooth_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_WEIGHT) begin
                weight_reg <= pwdata[W_W-1:0];
            end
            if (s_fire) begin
                if (s_tuser[0] == MODE_CAPTURE) begin
                    base_reg     <= last_reg;
                    base_set_reg <= 1'b1;
                    smooth_reg   <= '0;
                end else begin
                    last_reg <= p_clamp;
                end
            end
            if (state_reg == S_ARND) begin
                smooth_reg <= S_W'(s_round);
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_reg <= p_clamp;
        end
        if (div_done) begin
            norm_reg <= div_q;
            e_reg    <= 5'(QUO_W - 1);
        end else if (state_reg == S_NORM && !norm_reg[QUO_W-1]) begin
            norm_reg <= norm_reg << 1;
            e_reg    <= e_reg - 1'b1;
        end
        if (state_reg == S_LSUM) l_reg <= l_next;
        if (state_reg == S_YRND) y_reg <= 32'(y_round);
        if (state_reg == S_ESUM) d_reg <= $signed((32'd1 << LQ) - pw_sh);
        if (state_reg == S_HRND) begin
            if (h_round > H_MAX) begin
                h_reg <= S_W'(H_MAX);
            end else if (h_round < H_MIN) begin
                h_reg <= S_W'(H_MIN);
            end else begin
                h_reg <= S_W'(h_round);
            end
        end
        if (state_reg == S_AMUL2) acc_reg <= prod;
        if (state_reg == S_ASUM)  acc_reg <= acc_reg + prod;
        if (load_out) begin
            m_tdata_reg <= {base_set_reg, smooth_reg[H_W-1:0]};
        end
    end

    // ratio divider
    bra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (p_clamp),
        .divisor  (base_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared multiplier
    bra_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign prdata   = {{(32-W_W){1'b0}}, weight_reg};
    assign pready   = 1'b1;

    // divider only runs while the sequencer waits for it
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // quotient arrives only in the divide step
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide step");

    // a capture request sets the base flag
    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser[0] == MODE_CAPTURE) |=> base_set_reg)
        else $error("capture did not set base");

    // a new result only comes from the output step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output step");

    // p_reg is the sample in work
    a_p_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LMUL) |-> (p_reg == last_reg))
        else $error("sample changed during computation");

endmodule

FILE: tb/barometric_relative_altitude_tb.sv
// Self-checking testbench for barometric_relative_altitude: drives sample and
// capture requests, predicts each smoothed height and compares every result.
// Depends on bra_pkg and the rtl top level only.
module barometric_relative_altitude_tb;
    import bra_pkg::*;

    typedef struct packed {
        logic           mode;
        logic [P_W-1:0] pressure;
    } baro_req_t;

    typedef struct packed {
        logic signed [H_W-1:0] height;
        logic                  base_valid;
    } baro_res_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int LONG_HOLD      = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [16:0] pressure_pa
    logic [0:0]  s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] relative_height, [31] base_valid
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    barometric_relative_altitude dut (.*);

    // clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // pending requests and expected results
    baro_req_t req_q[$];
    baro_res_t height_q[$];

    // predictor state
    longint unsigned log_tab[0:TABLE_ENTRIES];
    longint unsigned pow_tab[0:TABLE_ENTRIES];
    logic [W_W-1:0]  weight_reg;
    logic [P_W-1:0]  last_p;
    logic [P_W-1:0]  base_p;
    logic            base_ok;
    longint          smooth_h;

    int mismatches;
    int n_results;
    int n_captures;
    int n_clamped;

    // sender and receiver controls
    int gap_max;
    int stall_pct;
    int hold_asked;
    int hold_done;
    int hold_cnt;
    int burst_left;
    int gap_left;
    logic s_fire;

    // tables of log2(1+i/N) and 2^(i/N), Q28
    task automatic fill_tables();
        longint unsigned v, acc, x, term, total;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            v = ((longint'(TABLE_ENTRIES) + i) << 30) / TABLE_ENTRIES;
            acc = 0;
            if (v >= (64'd2 << 30)) begin
                log_tab[i] = 64'd1 << LQ;
            end else begin
                for (int k = 0; k <= LQ; k++) begin
                    v = (v * v) >> 30;
                    acc = acc << 1;
                    if (v >= (64'd2 << 30)) begin
                        v = v >> 1;
                        acc = acc | 1;
                    end
                end
                log_tab[i] = (acc + 1) >> 1;
            end
            x = (longint'(i) * 64'd744261118 + TABLE_ENTRIES / 2) / TABLE_ENTRIES;
            term = 64'd1 << 30;
            total = term;
            for (int k = 1; k < 25 && term != 0; k++) begin
                term = ((term * x) >> 30) / k;
                total = total + term;
            end
            pow_tab[i] = (total + 2) >> 2;
        end
    endtask

    // round half away from zero and shift
    function automatic longint rnd_shift(longint v, int sh);
        longint unsigned u;
        u = (v < 0) ? longint'(-v) : v;
        u = (u + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(u) : longint'(u);
    endfunction

    // height above base in Q16.16 from the hypsometric formula
    function automatic longint height_above(logic [P_W-1:0] p, logic [P_W-1:0] b);
        longint unsigned ratio, mant, s, t, idx, rem, diff, frac, pw;
        longint lg, y, yo, d, h;
        int e, n;
        ratio = (longint'(p) << LQ) / b;
        e = 63;
        while (e > 0 && ratio[e] == 1'b0) e--;
        mant = ratio - (64'd1 << e);
        s = (e >= 20) ? (mant >> (e - 20)) : (mant << (20 - e));
        t = s * TABLE_ENTRIES;
        idx = t >> 20;
        rem = t & 64'hFFFFF;
        diff = log_tab[idx + 1] - log_tab[idx];
        lg = (longint'(e) << LQ) + longint'(log_tab[idx])
            + longint'((diff * rem + (64'd1 << 19)) >> 20) - (longint'(LQ) << LQ);
        y = rnd_shift(lg * 51073335, LQ);
        yo = y + (64'sd8 << LQ);
        if (yo < 0) yo = 0;
        n = int'(yo >> LQ) - 8;
        frac = yo & ((64'd1 << LQ) - 1);
        t = frac * TABLE_ENTRIES;
        idx = t >> LQ;
        rem = t & ((64'd1 << LQ) - 1);
        diff = pow_tab[idx + 1] - pow_tab[idx];
        pw = pow_tab[idx] + ((diff * rem + (64'd1 << (LQ - 1))) >> LQ);
        if (n > 1) n = 1;
        if (n < -2) n = -2;
        pw = (n >= 0) ? (pw << n) : (pw >> (-n));
        d = (64'sd1 << LQ) - longint'(pw);
        h = rnd_shift(d * 64'sd2905261343, LQ + 16 - FRAC_BITS);
        if (h > 64'sd1073741823) h = 64'sd1073741823;
        if (h < -64'sd1073741824) h = -64'sd1073741824;
        return h;
    endfunction

    // advance the predictor by one accepted request
    function automatic baro_res_t predict_height(baro_req_t r);
        baro_res_t res;
        logic [P_W-1:0] p;
        longint w, acc;
        if (r.mode == MODE_CAPTURE) begin
            base_p = last_p;
            base_ok = 1'b1;
            smooth_h = 0;
            n_captures++;
        end else begin
            p = r.pressure;
            if (p < P_MIN) p = P_MIN;
            if (p > P_MAX) p = P_MAX;
            if (p != r.pressure) n_clamped++;
            last_p = p;
            if (base_ok && base_p != 0) begin
                w = (weight_reg > W_ONE) ? 65536 : longint'(weight_reg);
                acc = (65536 - w) * smooth_h + w * height_above(p, base_p);
                smooth_h = rnd_shift(acc, 16);
            end
        end
        res.height = smooth_h[H_W-1:0];
        res.base_valid = base_ok;
        return res;
    endfunction

    // request driver: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (req_q.size() > 0) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= {req_q[0].mode, 7'd0, req_q[0].pressure};
                void'(req_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls and an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 0;
        end else if (hold_done < hold_asked) begin
            hold_done <= hold_done + 1;
            hold_cnt <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor: predict on request, check on result
    always @(posedge aclk) begin
        baro_res_t exp_res;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            height_q.push_back(predict_height({s_tuser[0], s_tdata[P_W-1:0]}));
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (height_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end else begin
                exp_res = height_q.pop_front();
                if (m_tdata[H_W-1:0] !== exp_res.height
                        || m_tdata[31] !== exp_res.base_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: height exp %0d got %0d, base_valid exp %0b got %0b",
                            exp_res.height, $signed(m_tdata[H_W-1:0]),
                            exp_res.base_valid, m_tdata[31]);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", height_q.size());
                $display("barometric_relative_altitude_tb NOT OK");
                $finish;
            end
        end
    end

    // register write, setup then access
    task automatic write_weight(logic [W_W-1:0] w);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(4 * REG_WEIGHT);
        pwdata = 32'(w);
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        weight_reg = w;
    endtask

    // wait until every expected result has come, then let the block settle
    task automatic drain();
        while (req_q.size() > 0 || s_tvalid || height_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic baro_req_t mk(logic m, logic [P_W-1:0] p);
        baro_req_t r;
        r.mode = m;
        r.pressure = p;
        return r;
    endfunction

    // random sequence: mostly a sample, a capture, then a run of samples
    task automatic queue_random(int count);
        int base_pa;
        int left;
        left = count;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0: req_q.push_back(mk(MODE_CAPTURE, P_W'($urandom)));
                1: req_q.push_back(mk(MODE_SAMPLE, P_W'($urandom)));
                default: begin
                    base_pa = $urandom_range(30000, 110000);
                    req_q.push_back(mk(MODE_SAMPLE, P_W'(base_pa)));
                    req_q.push_back(mk(MODE_CAPTURE, P_W'($urandom)));
                    left -= 1;
                    repeat ($urandom_range(1, 20)) begin
                        if ($urandom_range(0, 3) == 0)
                            req_q.push_back(mk(MODE_SAMPLE, P_W'($urandom_range(30000, 110000))));
                        else
                            req_q.push_back(mk(MODE_SAMPLE,
                                P_W'($urandom_range(base_pa > 32000 ? base_pa - 2000 : 30000,
                                                   base_pa < 108000 ? base_pa + 2000 : 110000))));
                        left--;
                    end
                end
            endcase
            left--;
        end
    endtask

    // stimulus
    initial begin
        logic [W_W-1:0] weights[7];
        weights = '{17'd0, W_ONE, 17'h1FFFF, 17'd1, 17'd65535, 17'd32768, 17'd0};
        weights[6] = W_W'($urandom_range(0, 65536));
        fill_tables();
        weight_reg = W_RESET;
        last_p = '0;
        base_p = '0;
        base_ok = 1'b0;
        smooth_h = 0;
        mismatches = 0;
        n_results = 0;
        n_captures = 0;
        n_clamped = 0;
        gap_max = 4;
        stall_pct = 20;
        hold_asked = 0;
        s_fire = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: sample without base, capture, clamping, extremes
        req_q.push_back(mk(MODE_SAMPLE, 17'd101325));
        req_q.push_back(mk(MODE_CAPTURE, 17'd0));
        req_q.push_back(mk(MODE_SAMPLE, 17'd95000));
        req_q.push_back(mk(MODE_SAMPLE, 17'd0));
        req_q.push_back(mk(MODE_CAPTURE, 17'h1FFFF));
        req_q.push_back(mk(MODE_SAMPLE, 17'd30000));
        req_q.push_back(mk(MODE_SAMPLE, 17'd29999));
        req_q.push_back(mk(MODE_SAMPLE, 17'h1FFFF));
        req_q.push_back(mk(MODE_SAMPLE, 17'd110000));
        req_q.push_back(mk(MODE_SAMPLE, 17'd110001));
        req_q.push_back(mk(MODE_CAPTURE, 17'd12345));
        req_q.push_back(mk(MODE_SAMPLE, 17'd30000));
        req_q.push_back(mk(MODE_SAMPLE, 17'd110000));
        req_q.push_back(mk(MODE_SAMPLE, 17'd0));
        req_q.push_back(mk(MODE_CAPTURE, 17'd0));
        req_q.push_back(mk(MODE_SAMPLE, 17'd110000));
        req_q.push_back(mk(MODE_SAMPLE, 17'h15555));
        req_q.push_back(mk(MODE_SAMPLE, 17'h0AAAA));
        req_q.push_back(mk(MODE_SAMPLE, 17'd30000));
        req_q.push_back(mk(MODE_CAPTURE, 17'd0));
        req_q.push_back(mk(MODE_SAMPLE, 17'd30000));
        drain();

        // random phases, each under its own weight and one of three idling patterns
        for (int ph = 0; ph < 7; ph++) begin
            write_weight(weights[ph]);
            case (ph % 3)
                0: begin gap_max = 0; stall_pct = 0; end
                1: begin gap_max = 6; stall_pct = 40; end
                default: begin gap_max = 2; stall_pct = 15; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (ph == 2) begin
                gap_max = 0;
                hold_asked++;
            end
            queue_random(210);
            drain();
        end

        $display("%0d results checked, %0d captures, %0d clamped samples, 8 weight settings",
            n_results, n_captures, n_clamped);
        if (mismatches == 0)
            $display("barometric_relative_altitude_tb OK");
        else
            $display("barometric_relative_altitude_tb NOT OK");
        $finish;
    end

endmodule
